>>> hw/rtl/dhd_pkg.sv
// Package for the four-channel drum hit detector.
// Sizes, sensor positions, register indexes and the shared types.
// No dependencies.
package dhd_pkg;

   localparam int SENSORS        = 4;
   localparam int SAMPLE_BITS    = 12;
   localparam int TIME_BITS      = 32;
   localparam int DEBOUNCE_BITS  = 16;
   localparam int TIMEOUT_BITS   = 16;
   localparam int CSR_DATA_BITS  = SENSORS * SAMPLE_BITS;
   localparam int CSR_INDEX_BITS = 3;

   // Sensor positions: two side sensors at the ends, two center sensors between
   localparam int LEFT_SIDE    = 0;
   localparam int LEFT_CENTER  = 1;
   localparam int RIGHT_CENTER = 2;
   localparam int RIGHT_SIDE   = SENSORS - 1;

   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [SAMPLE_BITS-1:0]   sample_type;
   typedef logic [SENSORS-1:0]       mask_type;
   typedef logic [DEBOUNCE_BITS-1:0] debounce_type;
   typedef logic [TIMEOUT_BITS-1:0]  timeout_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_addr_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEBOUNCE     = 3'd0,
      CSR_KEY_TIMEOUT  = 3'd1,
      CSR_GHOST_SIDES  = 3'd2,
      CSR_GHOST_CENTER = 3'd3,
      CSR_ENABLE       = 3'd4,
      CSR_LIGHT_THR    = 3'd5,
      CSR_HEAVY_THR    = 3'd6
   } csr_index_type;

   typedef struct packed {
      debounce_type                    debounce_ms;
      timeout_type                     key_timeout_ms;
      logic                            ghost_block_sides;
      logic                            ghost_block_center;
      mask_type                        sensor_enable;
      logic [SENSORS-1:0][SAMPLE_BITS-1:0] light_thr;
      logic [SENSORS-1:0][SAMPLE_BITS-1:0] heavy_thr;
   } cfg_type;

   // One poll as held in the input register
   typedef struct packed {
      time_type                            now_ms;
      logic [SENSORS-1:0][SAMPLE_BITS-1:0] samples;
   } poll_type;

   // Decision of one sensor for the current poll
   typedef struct packed {
      logic pressed;
      logic hit;
      logic flag_next;
   } sensor_out_type;

endpackage

>>> hw/rtl/dhd_if.sv
// Channel interfaces of the drum hit detector: poll requests and results.
// Depends on dhd_pkg.
interface dhd_req_if;
   logic                 valid;
   logic                 ready;
   dhd_pkg::time_type    now_ms;
   dhd_pkg::sample_type  sample_left_side;
   dhd_pkg::sample_type  sample_left_center;
   dhd_pkg::sample_type  sample_right_center;
   dhd_pkg::sample_type  sample_right_side;

   modport source (
      output valid, now_ms, sample_left_side, sample_left_center,
             sample_right_center, sample_right_side,
      input  ready
   );
   modport sink (
      input  valid, now_ms, sample_left_side, sample_left_center,
             sample_right_center, sample_right_side,
      output ready
   );
endinterface

interface dhd_rsp_if;
   logic               valid;
   logic               ready;
   dhd_pkg::mask_type  pressed_mask;
   dhd_pkg::mask_type  new_hit_mask;

   modport source (output valid, pressed_mask, new_hit_mask, input ready);
   modport sink   (input valid, pressed_mask, new_hit_mask, output ready);
endinterface

>>> hw/rtl/dhd_csr.sv
// Configuration registers of the drum hit detector, written by index.
// Depends on dhd_pkg.
module dhd_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  dhd_pkg::csr_addr_type csr_index,
   input  dhd_pkg::csr_data_type csr_wdata,
   output dhd_pkg::cfg_type      cfg
);
   import dhd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE:     cfg_in.debounce_ms        = csr_wdata[DEBOUNCE_BITS-1:0];
            CSR_KEY_TIMEOUT:  cfg_in.key_timeout_ms     = csr_wdata[TIMEOUT_BITS-1:0];
            CSR_GHOST_SIDES:  cfg_in.ghost_block_sides  = csr_wdata[0];
            CSR_GHOST_CENTER: cfg_in.ghost_block_center = csr_wdata[0];
            CSR_ENABLE:       cfg_in.sensor_enable      = csr_wdata[SENSORS-1:0];
            CSR_LIGHT_THR:    cfg_in.light_thr          = csr_wdata;
            CSR_HEAVY_THR:    cfg_in.heavy_thr          = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, reset to their defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= DEBOUNCE_BITS'(15);
         cfg_ff.key_timeout_ms     <= TIMEOUT_BITS'(30);
         cfg_ff.ghost_block_sides  <= 1'b0;
         cfg_ff.ghost_block_center <= 1'b0;
         cfg_ff.sensor_enable      <= '1;
         cfg_ff.light_thr          <= '1;
         cfg_ff.heavy_thr          <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/dhd_sensor.sv
// Per-sensor decision for one poll: key release, debounce, thresholds.
// Depends on dhd_pkg.
module dhd_sensor (
   input  logic                    enable,
   input  logic                    flag,
   input  dhd_pkg::time_type       now_ms,
   input  dhd_pkg::time_type       last_hit,
   input  dhd_pkg::sample_type     sample,
   input  dhd_pkg::sample_type     light_thr,
   input  dhd_pkg::sample_type     heavy_thr,
   input  dhd_pkg::debounce_type   debounce_ms,
   input  dhd_pkg::timeout_type    key_timeout_ms,
   input  logic                    global_ok,
   input  logic                    ghost_ok,
   output dhd_pkg::sensor_out_type result
);
   import dhd_pkg::*;

   time_type elapsed;
   logic     held;
   logic     level_ok;
   logic     hit;

   // Time since this sensor's last hit, wrapping
   assign elapsed = now_ms - last_hit;

   // Keep the key pressed until the timeout has passed
   assign held = flag && (elapsed <= time_type'(key_timeout_ms));

   // Heavy hit always passes the level test, light hit only after the global debounce
   assign level_ok = (sample > heavy_thr) || ((sample > light_thr) && global_ok);

   assign hit = enable && !held && ghost_ok
                && (elapsed > time_type'(debounce_ms)) && level_ok;

   // A disabled sensor reports nothing and keeps its flag
   always_comb begin
      result.hit       = hit;
      result.pressed   = enable && (held || hit);
      result.flag_next = enable ? (held || hit) : flag;
   end

endmodule

>>> hw/rtl/drum_hit_detector_4ch_top.sv
// Top level of the four-channel drum hit detector.
// Depends on dhd_pkg, dhd_if, dhd_csr and dhd_sensor.
//
// Usage:
//   req_if carries one poll per transaction: a millisecond timestamp and one
//   ADC sample per piezo sensor. rsp_if returns one transaction per poll with
//   the pressed mask and the new-hit mask. csr_we/csr_index/csr_wdata write
//   the configuration registers; write them only while no poll is in flight.
//   A poll accepted at one clock edge is registered in the input register,
//   evaluated in a single pass against the sensor state, and then loaded into
//   the result register when it can advance.
//   Throughput: one poll per cycle while rsp_if.ready is high. The sensor
//   state (pressed flags, per-sensor and global hit times) is updated in the
//   same edge that loads the result register, so the next poll sees it straight away.
//   Stall: when rsp_if.ready is low the result register holds; the input
//   register still takes one more poll, then req_if.ready drops until the
//   result is taken.
//   Reset: synchronous, clears both pipeline valids, all pressed flags and hit
//   times, and restores the register defaults.
module drum_hit_detector_4ch_top (
   input  logic                  clock,
   input  logic                  reset,
   dhd_req_if.sink               req_if,
   dhd_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  dhd_pkg::csr_addr_type csr_index,
   input  dhd_pkg::csr_data_type csr_wdata
);
   import dhd_pkg::*;

   cfg_type        cfg;
   poll_type       in_ff;
   logic           in_valid_ff;
   logic           in_valid_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   mask_type       pressed_ff;
   mask_type       hits_ff;
   mask_type       flags_ff;
   mask_type       flags_in;
   time_type       last_hit_ff [SENSORS];
   time_type       last_hit_in [SENSORS];
   time_type       global_hit_ff;
   time_type       global_hit_in;
   logic           req_accept;
   logic           advance;
   logic           global_ok;
   logic           side_busy;
   logic           centre_busy;
   logic           side_ok;
   logic           center_ok;
   mask_type       ghost_ok;
   mask_type       pressed_now;
   mask_type       hits_now;
   sensor_out_type sens_out [SENSORS];

   dhd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: advance the input register into the result register
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the poll
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff.now_ms                <= req_if.now_ms;
         in_ff.samples[LEFT_SIDE]    <= req_if.sample_left_side;
         in_ff.samples[LEFT_CENTER]  <= req_if.sample_left_center;
         in_ff.samples[RIGHT_CENTER] <= req_if.sample_right_center;
         in_ff.samples[RIGHT_SIDE]   <= req_if.sample_right_side;
      end
   end

   // Activity and global debounce, taken before the poll
   assign side_busy   = flags_ff[LEFT_SIDE] || flags_ff[RIGHT_SIDE];
   assign centre_busy = flags_ff[LEFT_CENTER] || flags_ff[RIGHT_CENTER];
   assign side_ok     = !(cfg.ghost_block_center && centre_busy);
   assign center_ok   = !(cfg.ghost_block_sides && side_busy);
   assign global_ok   = (in_ff.now_ms - global_hit_ff) > time_type'(cfg.debounce_ms);

   // Evaluate every sensor in parallel
   for (genvar k = 0; k < SENSORS; k++) begin : g_sensor
      assign ghost_ok[k] = ((k == LEFT_SIDE) || (k == RIGHT_SIDE)) ? side_ok : center_ok;

      dhd_sensor u_sensor (
         .enable         (cfg.sensor_enable[k]),
         .flag           (flags_ff[k]),
         .now_ms         (in_ff.now_ms),
         .last_hit       (last_hit_ff[k]),
         .sample         (in_ff.samples[k]),
         .light_thr      (cfg.light_thr[k]),
         .heavy_thr      (cfg.heavy_thr[k]),
         .debounce_ms    (cfg.debounce_ms),
         .key_timeout_ms (cfg.key_timeout_ms),
         .global_ok      (global_ok),
         .ghost_ok       (ghost_ok[k]),
         .result         (sens_out[k])
      );
   end

   // Gather masks and next state
   always_comb begin
      for (int k = 0; k < SENSORS; k++) begin
         pressed_now[k]  = sens_out[k].pressed;
         hits_now[k]     = sens_out[k].hit;
         flags_in[k]     = sens_out[k].flag_next;
         last_hit_in[k]  = sens_out[k].hit ? in_ff.now_ms : last_hit_ff[k];
      end
      global_hit_in = (|hits_now) ? in_ff.now_ms : global_hit_ff;
   end

   // Update the sensor state when the poll moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff      <= '0;
         global_hit_ff <= '0;
         for (int k = 0; k < SENSORS; k++) begin
            last_hit_ff[k] <= '0;
         end
      end else if (advance) begin
         flags_ff      <= flags_in;
         global_hit_ff <= global_hit_in;
         for (int k = 0; k < SENSORS; k++) begin
            last_hit_ff[k] <= last_hit_in[k];
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance) begin
         pressed_ff <= pressed_now;
         hits_ff    <= hits_now;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pressed_mask = pressed_ff;
   assign rsp_if.new_hit_mask = hits_ff;

   // A new hit always shows as pressed
   a_hit_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((pressed_ff & hits_ff) == hits_ff))
      else $error("new hit without pressed bit");

   // Any hit moves the global hit time to the poll's timestamp
   a_global_time: assert property (@(posedge clock) disable iff (reset)
      (advance && (|hits_now)) |=> (global_hit_ff == $past(in_ff.now_ms)))
      else $error("global hit time not updated on hit");

   // A disabled sensor reports neither pressed nor hit
   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      advance |-> (((pressed_now | hits_now) & ~cfg.sensor_enable) == '0))
      else $error("disabled sensor reported activity");

endmodule
